// ----- design/wsts_pkg.sv -----
// shared types, codes and helpers for the work-stealing task source selector
package wsts_pkg;

   localparam int NSLOTS = 16;
   localparam int WID_W = 4;
   localparam int CNT_W = 5;
   localparam int MAX_WORKERS_DEF = 16;
   localparam int QDEPTH = 4;
   localparam int QPTR_W = 2;

   localparam logic [31:0] SEED = 32'h9e37_79b9;
   localparam logic [7:0] AGE_MAX = 8'd255;
   localparam logic [7:0] VALVE_RST = 8'd64;
   localparam logic [CNT_W-1:0] WORKERS_RST = 5'd8;

   typedef enum logic [2:0] {
      SRC_NONE  = 3'd0,
      SRC_HIGH  = 3'd1,
      SRC_VALVE = 3'd2,
      SRC_OWN   = 3'd3,
      SRC_NORM  = 3'd4,
      SRC_LOW   = 3'd5,
      SRC_STEAL = 3'd6
   } src_type;

   typedef enum logic [1:0] {
      CSR_VALVE   = 2'd0,
      CSR_WORKERS = 2'd1
   } csr_idx_type;

   typedef struct packed {
      logic [WID_W-1:0]  worker_id;
      logic              high;
      logic              normal;
      logic              low;
      logic              own;
      logic [NSLOTS-1:0] steal_mask;
   } item_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_stat_type;

   typedef struct packed {
      logic [7:0]       valve_threshold;
      logic [CNT_W-1:0] workers_in_use;
   } cfg_type;

   function automatic logic [31:0] xorshift32(input logic [31:0] s);
      logic [31:0] t;
      t = s ^ (s << 13);
      t = t ^ (t >> 17);
      t = t ^ (t << 5);
      return t;
   endfunction

endpackage

// ----- design/wsts_front.sv -----
// request stage: takes a word, classifies it and pushes it to the queue
module wsts_front import wsts_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_push,
   output logic              req_full,
   input  logic [WID_W-1:0]  req_worker_id,
   input  logic              req_high_ready,
   input  logic              req_normal_ready,
   input  logic              req_low_ready,
   input  logic [NSLOTS-1:0] req_deque_ready,
   input  q_stat_type        q_stat,
   output logic              q_push,
   output item_type          q_item
);

   logic     valid_ff, valid_in;
   item_type item_ff, item_in;
   logic     take;

   assign req_full = valid_ff && q_stat.full;
   assign take = req_push && !req_full;
   assign q_push = valid_ff && !q_stat.full;
   assign q_item = item_ff;

   always_comb begin
      item_in.worker_id = req_worker_id;
      item_in.high = req_high_ready;
      item_in.normal = req_normal_ready;
      item_in.low = req_low_ready;
      item_in.own = req_deque_ready[req_worker_id];
      // the requester never steals from itself
      item_in.steal_mask = req_deque_ready & ~(NSLOTS'(1) << req_worker_id);
      valid_in = valid_ff;
      if (q_push) begin
         valid_in = 1'b0;
      end
      if (take) begin
         valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (take) begin
         item_ff <= item_in;
      end
   end

endmodule

// ----- design/wsts_fifo.sv -----
// short queue of classified words between front and back
module wsts_fifo import wsts_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       push,
   input  item_type   wdata,
   input  logic       pop,
   output item_type   rdata,
   output q_stat_type stat
);

   item_type          mem_ff [QDEPTH];
   logic [QPTR_W-1:0] wptr_ff, rptr_ff;
   logic [QPTR_W:0]   cnt_ff, cnt_in;
   logic              do_push, do_pop;

   assign stat.full = (cnt_ff == (QPTR_W+1)'(QDEPTH));
   assign stat.empty = (cnt_ff == '0);
   assign do_push = push && !stat.full;
   assign do_pop = pop && !stat.empty;
   assign rdata = mem_ff[rptr_ff];

   always_comb begin
      cnt_in = cnt_ff;
      case ({do_push, do_pop})
         2'b10: cnt_in = cnt_ff + 1'b1;
         2'b01: cnt_in = cnt_ff - 1'b1;
         default: cnt_in = cnt_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= '0;
         rptr_ff <= '0;
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
         if (do_push) begin
            wptr_ff <= wptr_ff + 1'b1;
         end
         if (do_pop) begin
            rptr_ff <= rptr_ff + 1'b1;
         end
      end
      if (do_push) begin
         mem_ff[wptr_ff] <= wdata;
      end
   end

endmodule

// ----- design/wsts_back.sv -----
// grant engine: per-worker aging and generator state, modulo unit, steal scan
module wsts_back import wsts_pkg::*; #(
   parameter int MAX_WORKERS = MAX_WORKERS_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  cfg_type          cfg,
   input  item_type         q_item,
   input  q_stat_type       q_stat,
   output logic             q_pop,
   output logic             rsp_empty,
   input  logic             rsp_pop,
   output logic             rsp_found,
   output logic [2:0]       rsp_source,
   output logic [WID_W-1:0] rsp_victim
);

   localparam int LIM = (MAX_WORKERS > NSLOTS) ? NSLOTS : MAX_WORKERS;

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_EVAL = 4'b0010,
      ST_MOD  = 4'b0100,
      ST_SCAN = 4'b1000
   } state_type;

   state_type         state_ff, state_in;
   item_type          item_ff;
   logic [7:0]        aging_ff [NSLOTS];
   logic [31:0]       rand_ff [NSLOTS];
   logic [31:0]       rnd_ff;
   logic [CNT_W-1:0]  rem_ff, rem_in;
   logic [1:0]        cnt_ff;
   logic              out_valid_ff;
   src_type           out_src_ff;
   logic [WID_W-1:0]  out_vic_ff;

   logic [CNT_W-1:0]  n_eff;
   logic [NSLOTS-1:0] active, cand;
   logic [7:0]        age_cur;
   src_type           eval_src;
   logic              eval_done;
   logic [31:0]       rnd_next;
   logic              hit_hi, hit_any;
   logic [WID_W-1:0]  idx_hi, idx_any, steal_vic;
   logic [WID_W-1:0]  wid;
   logic              write_out;
   src_type           wr_src;
   logic [WID_W-1:0]  wr_vic;

   assign wid = item_ff.worker_id;
   assign age_cur = aging_ff[wid];
   assign rnd_next = xorshift32(rand_ff[wid]);

   // clamp the configured worker count
   always_comb begin
      if (cfg.workers_in_use == '0) begin
         n_eff = CNT_W'(1);
      end else if (cfg.workers_in_use > CNT_W'(LIM)) begin
         n_eff = CNT_W'(LIM);
      end else begin
         n_eff = cfg.workers_in_use;
      end
      for (int i = 0; i < NSLOTS; i++) begin
         active[i] = (CNT_W'(i) < n_eff);
      end
   end

   always_comb begin
      eval_done = 1'b1;
      if (item_ff.high) begin
         eval_src = SRC_HIGH;
      end else if (age_cur >= cfg.valve_threshold && item_ff.low) begin
         eval_src = SRC_VALVE;
      end else if (item_ff.own) begin
         eval_src = SRC_OWN;
      end else if (item_ff.normal) begin
         eval_src = SRC_NORM;
      end else if (item_ff.low) begin
         eval_src = SRC_LOW;
      end else begin
         eval_src = SRC_NONE;
         eval_done = (n_eff <= CNT_W'(1));
      end
   end

   // remainder by the worker count, eight dividend bits per cycle
   always_comb begin
      logic [CNT_W-1:0] t;
      rem_in = rem_ff;
      for (int k = 0; k < 8; k++) begin
         t = {rem_in[CNT_W-2:0], rnd_ff[31-k]};
         if (t >= n_eff) begin
            t = t - n_eff;
         end
         rem_in = t;
      end
   end

   // first candidate at or after the start, else first overall
   always_comb begin
      cand = item_ff.steal_mask & active;
      hit_hi = 1'b0;
      hit_any = 1'b0;
      idx_hi = '0;
      idx_any = '0;
      for (int i = NSLOTS - 1; i >= 0; i--) begin
         if (cand[i]) begin
            hit_any = 1'b1;
            idx_any = WID_W'(i);
            if (WID_W'(i) >= rem_ff[WID_W-1:0]) begin
               hit_hi = 1'b1;
               idx_hi = WID_W'(i);
            end
         end
      end
      steal_vic = hit_hi ? idx_hi : idx_any;
   end

   always_comb begin
      state_in = state_ff;
      q_pop = 1'b0;
      write_out = 1'b0;
      wr_src = SRC_NONE;
      wr_vic = '0;
      case (state_ff)
         ST_IDLE: begin
            if (!q_stat.empty && !out_valid_ff) begin
               q_pop = 1'b1;
               state_in = ST_EVAL;
            end
         end
         ST_EVAL: begin
            if (eval_done) begin
               write_out = 1'b1;
               wr_src = eval_src;
               wr_vic = (eval_src == SRC_OWN) ? wid : '0;
               state_in = ST_IDLE;
            end else begin
               state_in = ST_MOD;
            end
         end
         ST_MOD: begin
            if (cnt_ff == 2'd3) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            write_out = 1'b1;
            wr_src = hit_any ? SRC_STEAL : SRC_NONE;
            wr_vic = hit_any ? steal_vic : '0;
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         out_valid_ff <= 1'b0;
         for (int i = 0; i < NSLOTS; i++) begin
            aging_ff[i] <= '0;
            rand_ff[i] <= SEED ^ 32'(i);
         end
      end else begin
         state_ff <= state_in;
         if (write_out) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_pop) begin
            out_valid_ff <= 1'b0;
         end
         if (state_ff == ST_EVAL && !eval_done) begin
            rand_ff[wid] <= rnd_next;
         end
         if (write_out) begin
            case (wr_src)
               SRC_VALVE, SRC_LOW: aging_ff[wid] <= '0;
               SRC_HIGH, SRC_OWN, SRC_NORM, SRC_STEAL: begin
                  if (age_cur != AGE_MAX) begin
                     aging_ff[wid] <= age_cur + 8'd1;
                  end
               end
               default: aging_ff[wid] <= age_cur;
            endcase
         end
      end
      if (q_pop) begin
         item_ff <= q_item;
      end
      if (state_ff == ST_EVAL) begin
         rnd_ff <= rnd_next;
         rem_ff <= '0;
         cnt_ff <= '0;
      end else if (state_ff == ST_MOD) begin
         rnd_ff <= rnd_ff << 8;
         rem_ff <= rem_in;
         cnt_ff <= cnt_ff + 2'd1;
      end
      if (write_out) begin
         out_src_ff <= wr_src;
         out_vic_ff <= wr_vic;
      end
   end

   assign rsp_empty = !out_valid_ff;
   assign rsp_found = (out_src_ff != SRC_NONE);
   assign rsp_source = out_src_ff;
   assign rsp_victim = out_vic_ff;

endmodule

// ----- design/work_stealing_task_source_select_top.sv -----
// top level of the work-stealing task source selector
//
//  channel   ports                         word accepted when
//  request   req_push/req_full + fields    req_push && !req_full
//  response  rsp_empty/rsp_pop + fields    rsp_pop && !rsp_empty
//  csr       csr_valid/csr_ready + idx/dat csr_valid && csr_ready
//
// a request is granted by the back end through its idle and eval states when
// a global queue or the own deque serves it, and through idle, eval, the
// remainder unit (8 bits of the random word per cycle) and the scan state
// when it goes to a steal scan. the back end starts a word only once the
// response slot is empty. reset is synchronous and restores all aging
// counters and generator seeds at once. the front and its 4-word queue keep
// taking requests while the back end or the response side stalls.
module work_stealing_task_source_select_top import wsts_pkg::*; #(
   parameter int MAX_WORKERS = MAX_WORKERS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_push,
   output logic              req_full,
   input  logic [WID_W-1:0]  req_worker_id,
   input  logic              req_high_ready,
   input  logic              req_normal_ready,
   input  logic              req_low_ready,
   input  logic [NSLOTS-1:0] req_deque_ready,
   output logic              rsp_empty,
   input  logic              rsp_pop,
   output logic              rsp_found,
   output logic [2:0]        rsp_source,
   output logic [WID_W-1:0]  rsp_victim,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [1:0]        csr_index,
   input  logic [7:0]        csr_data
);

   cfg_type    cfg_ff;
   q_stat_type q_stat;
   logic       q_push, q_pop;
   item_type   q_wdata, q_rdata;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.valve_threshold <= VALVE_RST;
         cfg_ff.workers_in_use <= WORKERS_RST;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_VALVE: cfg_ff.valve_threshold <= csr_data;
            CSR_WORKERS: cfg_ff.workers_in_use <= csr_data[CNT_W-1:0];
            default: cfg_ff <= cfg_ff;
         endcase
      end
   end

   wsts_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_push         (req_push),
      .req_full         (req_full),
      .req_worker_id    (req_worker_id),
      .req_high_ready   (req_high_ready),
      .req_normal_ready (req_normal_ready),
      .req_low_ready    (req_low_ready),
      .req_deque_ready  (req_deque_ready),
      .q_stat           (q_stat),
      .q_push           (q_push),
      .q_item           (q_wdata)
   );

   wsts_fifo u_fifo (
      .clock (clock),
      .reset (reset),
      .push  (q_push),
      .wdata (q_wdata),
      .pop   (q_pop),
      .rdata (q_rdata),
      .stat  (q_stat)
   );

   wsts_back #(
      .MAX_WORKERS (MAX_WORKERS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .q_item     (q_rdata),
      .q_stat     (q_stat),
      .q_pop      (q_pop),
      .rsp_empty  (rsp_empty),
      .rsp_pop    (rsp_pop),
      .rsp_found  (rsp_found),
      .rsp_source (rsp_source),
      .rsp_victim (rsp_victim)
   );

   // the front never pushes into a full queue
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(q_push && q_stat.full))
      else $error("queue push while full");

   // the back end never pulls from an empty queue
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      !(q_pop && q_stat.empty))
      else $error("queue pop while empty");

   // a victim is named only for own-deque and stolen grants
   a_victim_zero: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_source != SRC_OWN && rsp_source != SRC_STEAL)
      |-> (rsp_victim == '0))
      else $error("victim set for a global grant");

   // the reported source stays within the defined codes
   a_src_range: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> (rsp_source <= SRC_STEAL))
      else $error("source code out of range");

endmodule
